// ===== rtl/core/lnaf_pkg.sv =====
// ----------------------------------------------------------------------------
// lnaf_pkg
// Shared constants and types of the LMS/NLMS adaptive filter.
// ----------------------------------------------------------------------------
package lnaf_pkg;

    localparam int TAPS   = 64;
    localparam int ADDR_W = $clog2(TAPS);
    localparam int ACC_W  = 48 + ADDR_W;
    localparam int PWR_W  = 31 + ADDR_W;
    localparam int DVD_W  = 46;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int PADDR_W = 3;

    localparam logic REG_STEP = 1'b0;
    localparam logic REG_MODE = 1'b1;

    localparam logic [15:0] STEP_RESET = 16'd655;

    typedef struct packed {
        logic [15:0] step_size;
        logic        normalize_mode;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [PWR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/lms_nlms_adaptive_filter.sv =====
// ----------------------------------------------------------------------------
// lms_nlms_adaptive_filter
// Adaptive FIR filter with LMS or power-normalized LMS weight update.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    kind, sample_in
//   output    out_valid / out_ready  error_out
//   config    APB psel/penable       paddr, pwdata, prdata
//
// A sample word makes two passes over the weight and history memories, one
// read each per cycle: an estimate pass and an update pass, with a divider
// run between them in NLMS mode. A clear word zeroes both memories. After
// reset a clearing pass zeroes both memories while in_ready stays low.
// A new word is taken while a finished error word still waits at the output.
// ----------------------------------------------------------------------------
module lms_nlms_adaptive_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic signed [15:0]           sample_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [15:0]           error_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lnaf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lnaf_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLR  = 4'd1;
    localparam logic [3:0] ST_WRS  = 4'd2;
    localparam logic [3:0] ST_EST  = 4'd3;
    localparam logic [3:0] ST_ESTW = 4'd4;
    localparam logic [3:0] ST_ERR  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_GE   = 4'd7;
    localparam logic [3:0] ST_UPD  = 4'd8;
    localparam logic [3:0] ST_UPDW = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TAPS - 1);

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [3:0]              state_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic [ADDR_W-1:0]       head_reg;
    logic signed [15:0]      x_reg;
    logic                    clr_out_reg;
    logic                    p1_v_reg;
    logic                    p2_v_reg;
    logic [ADDR_W-1:0]       a1_reg;
    logic [ADDR_W-1:0]       a2_reg;
    logic signed [31:0]      w_rd_reg;
    logic signed [15:0]      h_rd_reg;
    logic signed [47:0]      prod_wx_reg;
    logic [30:0]             prod_xx_reg;
    logic signed [31:0]      w_d_reg;
    logic signed [64:0]      upd_prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [PWR_W-1:0]        pwr_reg;
    logic signed [15:0]      err_reg;
    logic [31:0]             g_reg;
    logic signed [48:0]      ge_reg;
    logic                    out_valid_reg;
    logic signed [15:0]      out_data_reg;

    logic signed [31:0] w_mem [TAPS];
    logic signed [15:0] h_mem [TAPS];

    logic                    issue;
    logic                    est_pass;
    logic                    upd_pass;
    logic [ADDR_W-1:0]       head_dec;
    logic [ADDR_W:0]         phys_sum;
    logic [ADDR_W-1:0]       h_raddr;
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic signed [31:0]      w_wdata;
    logic                    h_we;
    logic [ADDR_W-1:0]       h_waddr;
    logic signed [15:0]      h_wdata;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [ACC_W-28:0] diff;
    logic signed [15:0]      err_sat;
    logic signed [31:0]      sq;
    logic signed [64:0]      upd_rnd;
    logic signed [47:0]      w_sum;
    logic signed [31:0]      w_sat;
    logic [31:0]             q_sat;

    lnaf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lnaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign error_out = out_data_reg;

    assign issue    = (state_reg == ST_EST) || (state_reg == ST_UPD);
    assign est_pass = (state_reg == ST_EST) || (state_reg == ST_ESTW);
    assign upd_pass = (state_reg == ST_UPD) || (state_reg == ST_UPDW);
    assign head_dec = (head_reg == '0) ? LAST : head_reg - 1'b1;
    assign phys_sum = {1'b0, head_reg} + {1'b0, idx_reg};
    assign h_raddr  = (phys_sum >= (ADDR_W + 1)'(TAPS))
                    ? ADDR_W'(phys_sum - (ADDR_W + 1)'(TAPS)) : phys_sum[ADDR_W-1:0];

    assign acc_rnd = acc_reg + ACC_W'(64'sd134217728);
    assign diff    = (ACC_W - 27)'(x_reg)
                   - (ACC_W - 27)'($signed(acc_rnd[ACC_W-1:28]));
    always_comb
    begin
        priority if (diff > (ACC_W - 27)'(32767))
        begin
            err_sat = 16'sh7fff;
        end
        else if (diff < -(ACC_W - 27)'(32768))
        begin
            err_sat = -16'sh8000;
        end
        else
        begin
            err_sat = diff[15:0];
        end
    end

    assign sq      = h_rd_reg * h_rd_reg;
    assign upd_rnd = upd_prod_reg + 65'sd131072;
    assign w_sum   = 48'(w_d_reg) + 48'($signed(upd_rnd[64:18]));
    always_comb
    begin
        priority if (w_sum > 48'sh7fffffff)
        begin
            w_sat = 32'sh7fffffff;
        end
        else if (w_sum < -48'sh80000000)
        begin
            w_sat = -32'sh80000000;
        end
        else
        begin
            w_sat = w_sum[31:0];
        end
    end

    assign q_sat = (div_rsp.quotient[DVD_W-1:32] != '0) ? 32'hffffffff
                 : div_rsp.quotient[31:0];

    assign div_req.start    = (state_reg == ST_ERR) && cfg.normalize_mode;
    assign div_req.dividend = {cfg.step_size, 30'd0};
    assign div_req.divisor  = pwr_reg;

    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = idx_reg;
        w_wdata = '0;
        h_we    = 1'b0;
        h_waddr = idx_reg;
        h_wdata = '0;
        if (state_reg == ST_CLR)
        begin
            w_we = 1'b1;
            h_we = 1'b1;
        end
        else if (state_reg == ST_WRS)
        begin
            h_we    = 1'b1;
            h_waddr = head_reg;
            h_wdata = x_reg;
        end
        else if (upd_pass && p2_v_reg)
        begin
            w_we    = 1'b1;
            w_waddr = a2_reg;
            w_wdata = w_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_waddr] <= w_wdata;
        end
        if (h_we)
        begin
            h_mem[h_waddr] <= h_wdata;
        end
        w_rd_reg <= w_mem[idx_reg];
        h_rd_reg <= h_mem[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= idx_reg;
        a2_reg <= a1_reg;
        if (p1_v_reg)
        begin
            prod_wx_reg  <= w_rd_reg * h_rd_reg;
            prod_xx_reg  <= sq[30:0];
            upd_prod_reg <= ge_reg * h_rd_reg;
            w_d_reg      <= w_rd_reg;
        end
        if (state_reg == ST_WRS)
        begin
            acc_reg <= '0;
            pwr_reg <= PWR_W'(1);
        end
        else if (est_pass && p2_v_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_wx_reg);
            pwr_reg <= pwr_reg + PWR_W'(prod_xx_reg);
        end
        if (state_reg == ST_ERR && !cfg.normalize_mode)
        begin
            g_reg <= {16'd0, cfg.step_size};
        end
        else if (state_reg == ST_DIV && div_rsp.done)
        begin
            g_reg <= q_sat;
        end
        if (state_reg == ST_GE)
        begin
            ge_reg <= $signed({1'b0, g_reg}) * err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            idx_reg       <= '0;
            head_reg      <= '0;
            x_reg         <= '0;
            clr_out_reg   <= 1'b0;
            err_reg       <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            p1_v_reg <= issue;
            p2_v_reg <= p1_v_reg;
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_valid)
                    begin
                        if (kind)
                        begin
                            clr_out_reg <= 1'b1;
                            err_reg     <= '0;
                            state_reg   <= ST_CLR;
                        end
                        else
                        begin
                            x_reg     <= sample_in;
                            head_reg  <= head_dec;
                            state_reg <= ST_WRS;
                        end
                    end
                end
                ST_CLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= clr_out_reg ? ST_OUT : ST_IDLE;
                    end
                end
                ST_WRS:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_EST;
                end
                ST_EST:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_ESTW;
                    end
                end
                ST_ESTW:
                begin
                    if (!p1_v_reg && !p2_v_reg)
                    begin
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR:
                begin
                    err_reg   <= err_sat;
                    state_reg <= cfg.normalize_mode ? ST_DIV : ST_GE;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_GE;
                    end
                end
                ST_GE:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_UPDW;
                    end
                end
                ST_UPDW:
                begin
                    if (!p1_v_reg && !p2_v_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= err_reg;
                        clr_out_reg   <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("filter stayed idle after taking a word");

    a_weight_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        w_we |-> (state_reg == ST_CLR || state_reg == ST_UPD || state_reg == ST_UPDW))
        else $error("weight memory written outside clear or update");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && state_reg == ST_OUT) |=> (state_reg == ST_OUT))
        else $error("result posted while the previous one was pending");

endmodule

// ===== rtl/core/lnaf_regs.sv =====
// ----------------------------------------------------------------------------
// lnaf_regs
// APB register file holding the step size and the normalization mode.
// ----------------------------------------------------------------------------
module lnaf_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lnaf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output lnaf_pkg::cfg_t               cfg
);
    import lnaf_pkg::*;

    logic [15:0] step_reg;
    logic        mode_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_STEP: step_reg <= pwdata[15:0];
                REG_MODE: mode_reg <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_STEP: prdata = {16'd0, step_reg};
            REG_MODE: prdata = {31'd0, mode_reg};
        endcase
    end

    assign cfg.step_size      = step_reg;
    assign cfg.normalize_mode = mode_reg;

endmodule

// ===== rtl/core/lnaf_div.sv =====
// ----------------------------------------------------------------------------
// lnaf_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnaf_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lnaf_pkg::div_req_t   req,
    output lnaf_pkg::div_rsp_t   rsp
);
    import lnaf_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PWR_W-1:0] rem_reg;
    logic [DVD_W-1:0] q_reg;
    logic [PWR_W-1:0] dvs_reg;
    logic [PWR_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            q_reg   <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= PWR_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[PWR_W-1:0];
            end
            q_reg <= {q_reg[DVD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives sample and clear words into the adaptive filter under random idling
// and stalls, predicts every error word with an internal LMS/NLMS model, and
// compares the output words in order. Step size and mode are changed between
// phases over the APB port while the filter is idle.
// ----------------------------------------------------------------------------
module testbench;
    import lnaf_pkg::*;

    typedef enum logic { KIND_SAMPLE = 1'b0, KIND_CLEAR = 1'b1 } kind_e;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic signed [15:0] sample_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] error_out;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    lms_nlms_adaptive_filter dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .sample_in(sample_in), .out_valid(out_valid),
        .out_ready(out_ready), .error_out(error_out), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    word_t pending_words[$];
    logic signed [15:0] expected_errors[$];
    logic [15:0] mu;
    logic nlms;
    logic signed [31:0] weights[TAPS];
    logic signed [15:0] history[TAPS];
    int mismatches = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_off = 0;
    bit failed = 1'b0;

    function automatic logic signed [15:0] filter_error(word_t w);
        longint acc;
        longint est;
        longint g;
        longint diff;
        longint delta;
        longint nw;
        longint unsigned power;
        longint unsigned q;
        int err;
        if (w.kind == KIND_CLEAR) begin
            for (int i = 0; i < TAPS; i++) begin
                weights[i] = '0;
                history[i] = '0;
            end
            return '0;
        end
        for (int i = TAPS - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = w.sample;
        acc = 0;
        for (int i = 0; i < TAPS; i++) acc += longint'(weights[i]) * longint'(history[i]);
        est = (acc + (64'sd1 <<< 27)) >>> 28;
        diff = longint'($signed(w.sample)) - est;
        err = diff > 32767 ? 32767 : (diff < -32768 ? -32768 : int'(diff));
        if (nlms) begin
            power = 1;
            for (int i = 0; i < TAPS; i++)
                power += longint'(history[i]) * longint'(history[i]);
            q = (longint'(mu) << 30) / power;
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            g = longint'(q);
        end else begin
            g = longint'(mu);
        end
        for (int i = 0; i < TAPS; i++) begin
            delta = (g * (longint'(err) * longint'(history[i])) + (64'sd1 <<< 17)) >>> 18;
            nw = longint'(weights[i]) + delta;
            if (nw > 64'sd2147483647) nw = 64'sd2147483647;
            if (nw < -64'sd2147483648) nw = -64'sd2147483648;
            weights[i] = nw[31:0];
        end
        return err[15:0];
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (in_valid && in_ready) begin
            in_valid <= 1'b0;
            send_gap <= $urandom_range(0, 14) * ($urandom_range(0, 3) == 0 ? 0 : 1);
        end else if (!in_valid && send_gap > 0) begin
            send_gap <= send_gap - 1;
        end else if (!in_valid && rst_n && pending_words.size() > 0) begin
            in_valid <= 1'b1;
            kind <= pending_words[0].kind;
            sample_in <= pending_words[0].sample;
            expected_errors.insert(expected_errors.size(), filter_error(pending_words[0]));
            void'(pending_words.pop_front());
        end
    end

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (expected_errors.size() == 0) begin
                failed <= 1'b1;
                if (mismatches < 10) $display("Unexpected error word %0d", error_out);
                mismatches <= mismatches + 1;
            end else begin
                if (error_out !== expected_errors[0]) begin
                    failed <= 1'b1;
                    if (mismatches < 10)
                        $display("Mismatch: expected %0d, got %0d",
                                 expected_errors[0], error_out);
                    mismatches <= mismatches + 1;
                end
                void'(expected_errors.pop_front());
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end else if (out_valid && out_ready) begin
            recv_gap <= $urandom_range(0, 14) * ($urandom_range(0, 3) == 0 ? 0 : 1);
            out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (cycles > 4000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == PADDR_W'(4 * REG_STEP)) mu = data[15:0];
        else if (addr == PADDR_W'(4 * REG_MODE)) nlms = data[0];
    endtask

    task automatic configure(input logic [15:0] step, input logic mode);
        apb_write(PADDR_W'(4 * REG_STEP), {16'h0, step});
        apb_write(PADDR_W'(4 * REG_MODE), {31'h0, mode});
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || expected_errors.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic queue_word(input logic k, input logic [15:0] s);
        word_t w;
        w.kind = k;
        w.sample = s;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic queue_random(input int count);
        int pick;
        int amp;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                queue_word(KIND_CLEAR, 16'($urandom));
            end else if (pick < 15) begin
                queue_word(KIND_SAMPLE, 16'($urandom));
            end else if (pick < 20) begin
                queue_word(KIND_SAMPLE, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            end else begin
                amp = 1 << $urandom_range(4, 14);
                queue_word(KIND_SAMPLE, 16'($signed($urandom_range(0, 2 * amp)) - amp));
            end
        end
    endtask

    initial begin
        mu = STEP_RESET;
        nlms = 1'b0;
        for (int i = 0; i < TAPS; i++) begin
            weights[i] = '0;
            history[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        queue_word(KIND_SAMPLE, 16'h7FFF);
        queue_word(KIND_SAMPLE, 16'h8000);
        queue_word(KIND_SAMPLE, 16'h0000);
        queue_word(KIND_SAMPLE, 16'hFFFF);
        queue_word(KIND_SAMPLE, 16'h0001);
        queue_word(KIND_CLEAR, 16'h1234);
        queue_word(KIND_SAMPLE, 16'h5555);
        queue_word(KIND_SAMPLE, 16'hAAAA);
        wait_idle();

        configure(16'hFFFF, 1'b0);
        for (int n = 0; n < 12; n++) queue_word(KIND_SAMPLE, n[0] ? 16'h8000 : 16'h7FFF);
        queue_word(KIND_CLEAR, 16'hFFFF);
        wait_idle();

        configure(16'hFFFF, 1'b1);
        queue_word(KIND_SAMPLE, 16'h0000);
        queue_word(KIND_SAMPLE, 16'h0001);
        queue_word(KIND_SAMPLE, 16'h7FFF);
        queue_word(KIND_SAMPLE, 16'h8000);
        wait_idle();

        hold_off = 2000;
        configure(16'd655, 1'b0);
        queue_random(250);
        wait_idle();
        configure(16'($urandom_range(1000, 20000)), 1'b1);
        queue_random(250);
        wait_idle();
        configure(16'h0000, 1'b1);
        queue_random(100);
        wait_idle();
        configure(16'($urandom), 1'b0);
        queue_random(200);
        wait_idle();
        configure(16'hFFFF, 1'b1);
        queue_random(150);
        wait_idle();

        if (!failed) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
